// ===== rtl/sitar_pkg.sv =====
// Shared types, constants and helpers for the signed integer to ASCII converter.
// No dependencies; imported by sitar_ctrl, sitar_dp and signed_int_to_ascii_radix.
package sitar_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int VALUE_W    = 32;
  localparam int CFG_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 6;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  // digit count saturates at MAX_DIGITS + 1
  localparam int CNT_W      = $clog2(MAX_DIGITS + 2);
  localparam int FIT_W      = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 2;

  // divider retires DIV_BITS quotient bits per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = VALUE_W / DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] RADIX_MIN  = CFG_W'(2);
  localparam logic [CFG_W-1:0] RADIX_MAX  = CFG_W'(36);
  localparam logic [CFG_W-1:0] BUFSZ_MIN  = CFG_W'(2);
  localparam logic [CFG_W-1:0] RADIX_RST  = CFG_W'(10);
  localparam logic [CFG_W-1:0] BUFSZ_RST  = CFG_W'(34);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // configuration register indexes
  localparam logic CFG_RADIX = 1'b0;
  localparam logic CFG_BUFSZ = 1'b1;

  typedef struct packed {
    logic load;        // capture a new input item
    logic div_step;    // one divider step
    logic rd_issue;    // read next digit, decrement count
    logic load_sign;   // put '-' in the output register
    logic load_digit;  // put the digit read last in the output register
    logic load_err;    // put the error result in the output register
  } sitar_cmd_t;

  typedef struct packed {
    logic cfg_bad;     // radix or buffer size invalid
    logic div_done;    // this divider cycle ends the last digit
    logic fits;        // sign, digits and terminator fit the buffer
    logic neg;         // item is negative
    logic last_digit;  // no digits left after this one
    logic out_free;    // output register can take a result this cycle
  } sitar_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      return CHAR_ZERO + ext;
    end
    return CHAR_ALPHA + ext;
  endfunction

endpackage

// ===== rtl/sitar_ctrl.sv =====
// Sequencer for the converter: accept, divide, fit check, error, sign and digit emission.
// Depends on sitar_pkg; drives sitar_dp through sitar_cmd_t.
module sitar_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sitar_pkg::sitar_sts_t sts,
  output sitar_pkg::sitar_cmd_t cmd
);
  import sitar_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_FIT  = 7'b0000100,
    S_ERR  = 7'b0001000,
    S_SIGN = 7'b0010000,
    S_RD   = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.cfg_bad ? S_ERR : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        if (!sts.fits) begin
          state_nxt = S_ERR;
        end else if (sts.neg) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.load_sign = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_digit = 1'b1;
          state_nxt      = sts.last_digit ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sitar_dp.sv =====
// Datapath: config registers, radix divider, digit store and output register.
// Depends on sitar_pkg; commanded by sitar_ctrl.
module sitar_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [sitar_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic signed [sitar_pkg::VALUE_W-1:0] in_value,
  input  sitar_pkg::sitar_cmd_t             cmd,
  output sitar_pkg::sitar_sts_t             sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sitar_pkg::CHAR_W-1:0]      out_character,
  output logic                              out_last,
  output logic                              out_error
);
  import sitar_pkg::*;

  logic [CFG_W-1:0]   radix_r, bufsz_r;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   count_r, count_dec;
  logic               neg_r;
  logic               digit_wr;
  logic               last_step;
  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r, out_error_r;
  logic               out_load;
  logic [FIT_W-1:0]   need_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RST;
      bufsz_r <= BUFSZ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX: radix_r <= cfg_wdata;
        CFG_BUFSZ: bufsz_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // restoring division, DIV_BITS quotient bits per cycle; remainder stays below radix
  always_comb begin
    logic [DIGIT_W:0]         t;
    logic [DIGIT_W-1:0]       r;
    logic [DIV_BITS-1:0]      q;
    r = rem_r;
    q = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, mag_r[VALUE_W-1-i]};
      if (t >= {1'b0, radix_r}) begin
        r                = DIGIT_W'(t - {1'b0, radix_r});
        q[DIV_BITS-1-i]  = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    rem_nxt = r;
    mag_nxt = {mag_r[VALUE_W-DIV_BITS-1:0], q};
  end

  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));
  assign digit_wr  = cmd.div_step && last_step && (count_r < CNT_W'(MAX_DIGITS));
  assign count_dec = count_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      step_r  <= '0;
      rem_r   <= '0;
      neg_r   <= 1'b0;
    end else if (cmd.load) begin
      count_r <= '0;
      step_r  <= '0;
      rem_r   <= '0;
      neg_r   <= in_value[VALUE_W-1];
    end else if (cmd.div_step) begin
      step_r <= step_r + STEP_W'(1);
      if (last_step) begin
        rem_r <= '0;
        if (count_r <= CNT_W'(MAX_DIGITS)) begin
          count_r <= count_r + CNT_W'(1);
        end
      end else begin
        rem_r <= rem_nxt;
      end
    end else if (cmd.rd_issue) begin
      count_r <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (digit_wr) begin
      mem[count_r[IDX_W-1:0]] <= rem_nxt;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[count_dec[IDX_W-1:0]];
    end
  end

  assign out_load = cmd.load_sign || cmd.load_digit || cmd.load_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_char_r  <= CHAR_NONE;
      out_last_r  <= 1'b1;
      out_error_r <= 1'b1;
    end else if (cmd.load_sign) begin
      out_char_r  <= CHAR_MINUS;
      out_last_r  <= 1'b0;
      out_error_r <= 1'b0;
    end else if (cmd.load_digit) begin
      out_char_r  <= digit_char(rd_data_r);
      out_last_r  <= (count_r == '0);
      out_error_r <= 1'b0;
    end
  end

  // sign + digits + terminator must not exceed the buffer
  assign need_w = FIT_W'(count_r) + FIT_W'(neg_r) + FIT_W'(1);

  always_comb begin
    sts            = '0;
    sts.cfg_bad    = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX) || (bufsz_r < BUFSZ_MIN);
    sts.div_done   = last_step && (mag_nxt == '0);
    sts.fits       = (need_w <= FIT_W'(bufsz_r)) && (count_r <= CNT_W'(MAX_DIGITS));
    sts.neg        = neg_r;
    sts.last_digit = (count_r == '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_error     = out_error_r;

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < radix_r))
    else $error("divider remainder reached radix");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register loaded while an item is pending");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (count_r != '0))
    else $error("digit read with empty store");

  a_last_digit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_digit && count_r == '0) |=> (out_valid && out_last && !out_error))
    else $error("final digit not flagged last");

endmodule

// ===== rtl/signed_int_to_ascii_radix.sv =====
// Top level of the signed integer to ASCII text converter, radix 2 to 36.
// Depends on sitar_pkg, sitar_ctrl and sitar_dp.
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, in_value             item in (32-bit signed)
//   out      out_valid/out_ready, out_character,     one item per character
//            out_last, out_error
//   cfg      cfg_we, cfg_index, cfg_wdata            register write, no wait
//
// Divider retires 4 quotient bits a cycle, passing over the whole magnitude for each digit.
// Then a fit check, a sign if negative, and per character a store read and a load.
// Synchronous active-low reset; radix resets to 10, buffer size to 34.
// A stalled output holds the sequencer; a new item is taken once the last one is queued.
module signed_int_to_ascii_radix (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [sitar_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sitar_pkg::VALUE_W-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sitar_pkg::CHAR_W-1:0]         out_character,
  output logic                                 out_last,
  output logic                                 out_error
);
  import sitar_pkg::*;

  sitar_cmd_t cmd;
  sitar_sts_t sts;

  sitar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sitar_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .out_error     (out_error)
  );

endmodule
